// ===== rtl/core/nrg_pkg.sv =====
package nrg_pkg;

    typedef struct packed {
        logic        op;
        logic [10:0] load_x;
        logic [8:0]  load_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] query_x;
        logic [11:0] query_y;
    } request_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       status;
    } result_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_READ,
        CMD_FLAG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } cmd_t;

    typedef struct packed {
        logic [11:0] w;
        logic [9:0]  h;
        logic [12:0] ow;
        logic [12:0] oh;
    } geom_t;

    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_TARGET_HEIGHT = 2'd3;

    localparam logic       OP_LOAD = 1'b0;

    localparam logic [15:0] LUMA_R     = 16'd19595;
    localparam logic [15:0] LUMA_G     = 16'd38470;
    localparam logic [15:0] LUMA_B     = 16'd7471;
    localparam logic [24:0] LUMA_ROUND = 25'd32768;

    // quotient bits of the coordinate divide; the mapped coordinate stays below 2^13
    localparam int QUOT_BITS = 13;
    localparam int NUM_BITS  = 27;

endpackage

// ===== rtl/core/nrg_front.sv =====
module nrg_front #(
    parameter int MAX_SOURCE_WIDTH  = 2048,
    parameter int MAX_SOURCE_HEIGHT = 512,
    parameter int MAX_OUTPUT_DIM    = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              req_push,
    input  nrg_pkg::request_t req,
    input  logic              q_full,
    output logic              q_push,
    output nrg_pkg::cmd_t     q_cmd,
    output nrg_pkg::geom_t    geom
);
    import nrg_pkg::*;

    logic [11:0] src_w_reg;
    logic [9:0]  src_h_reg;
    logic [12:0] tgt_w_reg;
    logic [12:0] tgt_h_reg;
    logic        load_ok;
    logic        read_ok;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_w_reg <= 12'd1242;
            src_h_reg <= 10'd375;
            tgt_w_reg <= 13'd0;
            tgt_h_reg <= 13'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data[11:0];
                CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data[9:0];
                CFG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                CFG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp source size to 1..max, then fold zero target onto source size and cap target at MAX_OUTPUT_DIM
    always_comb
    begin
        if (src_w_reg == 12'd0)
            geom.w = 12'd1;
        else if (32'(src_w_reg) > MAX_SOURCE_WIDTH)
            geom.w = 12'(MAX_SOURCE_WIDTH);
        else
            geom.w = src_w_reg;
        if (src_h_reg == 10'd0)
            geom.h = 10'd1;
        else if (32'(src_h_reg) > MAX_SOURCE_HEIGHT)
            geom.h = 10'(MAX_SOURCE_HEIGHT);
        else
            geom.h = src_h_reg;
        if (tgt_w_reg == 13'd0)
            geom.ow = {1'b0, geom.w};
        else if (32'(tgt_w_reg) > MAX_OUTPUT_DIM)
            geom.ow = 13'(MAX_OUTPUT_DIM);
        else
            geom.ow = tgt_w_reg;
        if (tgt_h_reg == 13'd0)
            geom.oh = {3'b0, geom.h};
        else if (32'(tgt_h_reg) > MAX_OUTPUT_DIM)
            geom.oh = 13'(MAX_OUTPUT_DIM);
        else
            geom.oh = tgt_h_reg;
    end

    assign load_ok = ({1'b0, req.load_x} < geom.w) && ({1'b0, req.load_y} < geom.h);
    assign read_ok = ({1'b0, req.query_x} < geom.ow) && ({1'b0, req.query_y} < geom.oh);

    // drop out-of-range loads here so the back never sees them
    always_comb
    begin
        q_cmd.red   = req.red;
        q_cmd.green = req.green;
        q_cmd.blue  = req.blue;
        if (req.op == OP_LOAD)
        begin
            q_cmd.kind = CMD_LOAD;
            q_cmd.cx   = {1'b0, req.load_x};
            q_cmd.cy   = {3'b0, req.load_y};
        end
        else
        begin
            q_cmd.kind = read_ok ? CMD_READ : CMD_FLAG;
            q_cmd.cx   = req.query_x;
            q_cmd.cy   = req.query_y;
        end
    end

    assign q_push = req_push && !q_full && (req.op != OP_LOAD || load_ok);

endmodule

// ===== rtl/core/nrg_queue.sv =====
module nrg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  nrg_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output nrg_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);
    import nrg_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd_en) else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/nrg_back.sv =====
module nrg_back #(
    parameter int MAX_SOURCE_WIDTH  = 2048,
    parameter int MAX_SOURCE_HEIGHT = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nrg_pkg::geom_t    geom,
    input  logic              q_empty,
    input  nrg_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output nrg_pkg::result_t  result
);
    import nrg_pkg::*;

    localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LUMA,
        ST_WRITE,
        ST_MUL,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic                  sel_y_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [13:0]           rem_reg;
    logic [QUOT_BITS-1:0]  quot_reg;
    logic [3:0]            cnt_reg;
    logic [11:0]           sx_reg;
    logic [11:0]           sy_reg;
    logic [22:0]           pr_reg;
    logic [23:0]           pg_reg;
    logic [22:0]           pb_reg;
    logic [7:0]            rdata_reg;
    logic                  flag_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [7:0]            mem [DEPTH];

    logic [11:0]           q_coord;
    logic [11:0]           dim;
    logic [12:0]           odim;
    logic [14:0]           den;
    logic [14:0]           trial;
    logic                  take;
    logic [QUOT_BITS-1:0]  quot_fin;
    logic [11:0]           clamped;
    logic [24:0]           luma_sum;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic                  rd_en;

    assign q_coord = sel_y_reg ? cmd_reg.cy : cmd_reg.cx;
    assign dim     = sel_y_reg ? {2'b0, geom.h} : geom.w;
    assign odim    = sel_y_reg ? geom.oh : geom.ow;
    assign den     = {1'b0, odim, 1'b0};

    // one restoring step: bring in the next numerator bit
    assign trial    = {rem_reg, num_reg[NUM_BITS-1]};
    assign take     = (trial >= den);
    assign quot_fin = {quot_reg[QUOT_BITS-2:0], take};
    assign clamped  = (quot_fin >= {1'b0, dim}) ? (dim - 12'd1) : quot_fin[11:0];

    assign luma_sum = 25'(pr_reg) + 25'(pg_reg) + 25'(pb_reg) + LUMA_ROUND;

    assign wr_addr = AW'(cmd_reg.cy * MAX_SOURCE_WIDTH + 32'(cmd_reg.cx));
    assign rd_addr = AW'(sy_reg * MAX_SOURCE_WIDTH + 32'(sx_reg));
    assign wr_en   = (state_reg == ST_WRITE);
    assign rd_en   = (state_reg == ST_RD);
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= luma_sum[23:16];
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sel_y_reg     <= 1'b0;
            cnt_reg       <= 4'd0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && pop && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_cmd;
                        sel_y_reg <= 1'b0;
                        case (q_cmd.kind)
                            CMD_LOAD:
                                state_reg <= ST_LUMA;
                            CMD_READ:
                            begin
                                flag_reg  <= 1'b0;
                                state_reg <= ST_MUL;
                            end
                            default:
                            begin
                                flag_reg  <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_LUMA:
                begin
                    pr_reg    <= 23'(cmd_reg.red * LUMA_R);
                    pg_reg    <= 24'(cmd_reg.green * LUMA_G);
                    pb_reg    <= 23'(cmd_reg.blue * LUMA_B);
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                    state_reg <= ST_IDLE;
                ST_MUL:
                begin
                    // numerator 2*q*dim + odim; top bits seed the remainder
                    num_reg   <= NUM_BITS'({24'(q_coord * dim), 1'b0}) + NUM_BITS'(odim);
                    state_reg <= ST_DIV;
                    cnt_reg   <= 4'd0;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        rem_reg <= num_reg[NUM_BITS-1 -: 14];
                        num_reg <= {num_reg[NUM_BITS-15:0], 14'd0};
                        quot_reg <= '0;
                        cnt_reg <= 4'd1;
                    end
                    else
                    begin
                        rem_reg  <= take ? 14'(trial - den) : trial[13:0];
                        num_reg  <= {num_reg[NUM_BITS-2:0], 1'b0};
                        quot_reg <= quot_fin;
                        if (cnt_reg == 4'(QUOT_BITS))
                        begin
                            cnt_reg <= 4'd0;
                            if (sel_y_reg)
                            begin
                                sy_reg    <= clamped;
                                state_reg <= ST_RD;
                            end
                            else
                            begin
                                sx_reg    <= clamped;
                                sel_y_reg <= 1'b1;
                                state_reg <= ST_MUL;
                            end
                        end
                        else
                            cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_RD:
                    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    // hold until the output register frees up
                    if (!out_valid_reg || pop)
                    begin
                        out_reg.gray   <= flag_reg ? 8'd0 : rdata_reg;
                        out_reg.status <= flag_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

`ifndef SYNTHESIS
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status) |-> (out_reg.gray == 8'd0))
        else $error("flagged result carries nonzero gray");
    a_sx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (sx_reg < geom.w && {2'b0, sy_reg[9:0]} < {2'b0, geom.h}))
        else $error("mapped coordinate outside source");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= 4'(QUOT_BITS)))
        else $error("divider step count overrun");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != ST_IDLE))
        else $error("command popped but not started");
`endif

endmodule

// ===== rtl/core/nearest_resize_rgb_to_gray.sv =====
// channel   direction  handshake            payload
// request   in         push / full          request_t (op, load and query fields)
// result    out        pop / empty          result_t (gray, status)
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load passes through the back end as products, then sum and store write.
// A read does, per coordinate in the shared divider, one multiply, a remainder
// seed and one restoring divide step per quotient bit, then a store read.
// An out-of-range read skips the divider. The two-entry command queue lets
// requests enter while the back end works; a waiting result stalls the back end.
// Reset clears control state only; the frame store is not cleared.
module nearest_resize_rgb_to_gray #(
    parameter int MAX_SOURCE_WIDTH  = 2048,
    parameter int MAX_SOURCE_HEIGHT = 512,
    parameter int MAX_OUTPUT_DIM    = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  nrg_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output nrg_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data
);
    import nrg_pkg::*;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    cmd_t  q_in;
    cmd_t  q_out;
    geom_t geom;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    nrg_front #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
        .MAX_OUTPUT_DIM    (MAX_OUTPUT_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_push  (push),
        .req       (request),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in),
        .geom      (geom)
    );

    nrg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in),
        .rd_en   (q_pop),
        .rd_data (q_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    nrg_back #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .q_empty (q_empty),
        .q_cmd   (q_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
